// ===== hdl/bcce_pkg.sv =====
// ----------------------------------------------------------------------------
// bcce_pkg
// Shared widths, chemistry codes, register indexes and constant tables of the
// battery cell count estimator.
// ----------------------------------------------------------------------------
package bcce_pkg;

  // Pack voltage width in bits.
  localparam int MV_BITS = 16;

  localparam int MODE_W     = 3;
  localparam int LIM_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CNT_W      = 5;
  localparam int CELL_MV_W  = 16;
  localparam int CNT_MAX     = 31;
  localparam int CELL_MV_MAX = 65535;

  // Per-cell limit constants are all below 8192 mV.
  localparam int CV_W = 13;
  // Reciprocal shift for the chemistry limit divides.
  localparam int CK   = MV_BITS + 2;
  localparam int CR_W = CK - 11;
  localparam int CX_W = MV_BITS + 1;
  localparam int CQ_W = MV_BITS - 9;
  localparam int CF_W = CQ_W + 1;
  localparam int CP_W = CK + CQ_W;
  localparam int CM_W = CQ_W + CV_W;

  // Per-cell voltage divider widths.
  localparam int DR_W = MV_BITS + 1;
  localparam int DP_W = 2 * MV_BITS + 1;
  localparam int DM_W = MV_BITS + CNT_W;

  localparam int NUM_STAGES = 7;
  localparam int DIV_STAGES = 3;

  typedef enum logic [MODE_W-1:0] {
    CHEM_NONE,
    CHEM_LIPO,
    CHEM_LIPO_SAFE,
    CHEM_LIHV,
    CHEM_LIHV_SAFE,
    CHEM_LIFE,
    CHEM_LIFE_SAFE,
    CHEM_INVALID
  } chem_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHEM_MODE,
    REG_LIPO_MAX,
    REG_LIHV_MAX,
    REG_LIFE_MAX
  } cfg_reg_e;

  typedef logic [CV_W-1:0] cell_v_t;
  typedef logic [CR_W-1:0] c_recip_t;
  typedef logic [DR_W-1:0] d_recip_t;

  localparam cell_v_t CELL_MIN_MV [8] = '{
    cell_v_t'(0), cell_v_t'(3100), cell_v_t'(3300), cell_v_t'(3100),
    cell_v_t'(3300), cell_v_t'(2500), cell_v_t'(2750), cell_v_t'(0)
  };

  localparam cell_v_t CELL_MAX_MV [8] = '{
    cell_v_t'(0), cell_v_t'(4200), cell_v_t'(4200), cell_v_t'(4350),
    cell_v_t'(4350), cell_v_t'(3650), cell_v_t'(3650), cell_v_t'(0)
  };

  // Truncated reciprocals; the quotient estimate is low by at most one.
  localparam c_recip_t RECIP_MIN [8] = '{
    c_recip_t'(0), c_recip_t'((2**CK) / 3100), c_recip_t'((2**CK) / 3300),
    c_recip_t'((2**CK) / 3100), c_recip_t'((2**CK) / 3300),
    c_recip_t'((2**CK) / 2500), c_recip_t'((2**CK) / 2750), c_recip_t'(0)
  };

  localparam c_recip_t RECIP_MAX [8] = '{
    c_recip_t'(0), c_recip_t'((2**CK) / 4200), c_recip_t'((2**CK) / 4200),
    c_recip_t'((2**CK) / 4350), c_recip_t'((2**CK) / 4350),
    c_recip_t'((2**CK) / 3650), c_recip_t'((2**CK) / 3650), c_recip_t'(0)
  };

  localparam d_recip_t CNT_RECIP [32] = '{
    d_recip_t'(0),                    d_recip_t'((2**MV_BITS) / 1),
    d_recip_t'((2**MV_BITS) / 2),     d_recip_t'((2**MV_BITS) / 3),
    d_recip_t'((2**MV_BITS) / 4),     d_recip_t'((2**MV_BITS) / 5),
    d_recip_t'((2**MV_BITS) / 6),     d_recip_t'((2**MV_BITS) / 7),
    d_recip_t'((2**MV_BITS) / 8),     d_recip_t'((2**MV_BITS) / 9),
    d_recip_t'((2**MV_BITS) / 10),    d_recip_t'((2**MV_BITS) / 11),
    d_recip_t'((2**MV_BITS) / 12),    d_recip_t'((2**MV_BITS) / 13),
    d_recip_t'((2**MV_BITS) / 14),    d_recip_t'((2**MV_BITS) / 15),
    d_recip_t'((2**MV_BITS) / 16),    d_recip_t'((2**MV_BITS) / 17),
    d_recip_t'((2**MV_BITS) / 18),    d_recip_t'((2**MV_BITS) / 19),
    d_recip_t'((2**MV_BITS) / 20),    d_recip_t'((2**MV_BITS) / 21),
    d_recip_t'((2**MV_BITS) / 22),    d_recip_t'((2**MV_BITS) / 23),
    d_recip_t'((2**MV_BITS) / 24),    d_recip_t'((2**MV_BITS) / 25),
    d_recip_t'((2**MV_BITS) / 26),    d_recip_t'((2**MV_BITS) / 27),
    d_recip_t'((2**MV_BITS) / 28),    d_recip_t'((2**MV_BITS) / 29),
    d_recip_t'((2**MV_BITS) / 30),    d_recip_t'((2**MV_BITS) / 31)
  };

endpackage

// ===== hdl/bcce_cell_div.sv =====
// ----------------------------------------------------------------------------
// bcce_cell_div
// Three-stage divider of the pack voltage by a cell count of up to 31:
// reciprocal multiply, back-multiply, then a one-step correction.
// ----------------------------------------------------------------------------
module bcce_cell_div (
  input  logic                                    clk_i,
  input  logic [bcce_pkg::DIV_STAGES-1:0]         en_i,
  input  logic [bcce_pkg::MV_BITS-1:0]            mv_i,
  input  logic [bcce_pkg::CNT_W-1:0]              cnt_i,
  output logic [bcce_pkg::CELL_MV_W-1:0]          cell_mv_o
);

  logic [bcce_pkg::DP_W-1:0]      prod_q;
  logic [bcce_pkg::MV_BITS-1:0]   mv0_q, mv1_q;
  logic [bcce_pkg::CNT_W-1:0]     cnt0_q, cnt1_q;
  logic [bcce_pkg::MV_BITS-1:0]   qe_d, qe1_q;
  logic [bcce_pkg::DM_W-1:0]      back1_q;
  logic [bcce_pkg::MV_BITS-1:0]   rem_d, quo_d;
  logic [bcce_pkg::CELL_MV_W-1:0] cell_mv_d, cell_mv_q;

  assign qe_d = prod_q[bcce_pkg::MV_BITS +: bcce_pkg::MV_BITS];

  always_comb begin
    rem_d = mv1_q - bcce_pkg::MV_BITS'(back1_q);
    quo_d = qe1_q + bcce_pkg::MV_BITS'(rem_d >= bcce_pkg::MV_BITS'(cnt1_q));
    if (32'(quo_d) > 32'(bcce_pkg::CELL_MV_MAX)) begin
      cell_mv_d = bcce_pkg::CELL_MV_W'(bcce_pkg::CELL_MV_MAX);
    end else begin
      cell_mv_d = bcce_pkg::CELL_MV_W'(quo_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= bcce_pkg::DP_W'(mv_i) * bcce_pkg::DP_W'(bcce_pkg::CNT_RECIP[cnt_i]);
      mv0_q  <= mv_i;
      cnt0_q <= cnt_i;
    end
    if (en_i[1]) begin
      back1_q <= bcce_pkg::DM_W'(qe_d) * bcce_pkg::DM_W'(cnt0_q);
      qe1_q   <= qe_d;
      mv1_q   <= mv0_q;
      cnt1_q  <= cnt0_q;
    end
    if (en_i[2]) begin
      cell_mv_q <= cell_mv_d;
    end
  end

  assign cell_mv_o = cell_mv_q;

endmodule

// ===== hdl/battery_cell_count_estimator.sv =====
// ----------------------------------------------------------------------------
// battery_cell_count_estimator
// Estimates the series cell count of a pack from its voltage and the chosen
// chemistry, with the per-cell voltage for each estimate.
// ----------------------------------------------------------------------------
// The block takes one pack voltage per cycle while the output side is not
// stalled and returns one result per input transfer. Four stages divide the
// voltage by the chemistry's per-cell limits (input register, reciprocal
// multiply, back-multiply, then correction with count clamping) and three
// more divide the voltage by each chosen count. Every stage holds its item
// only while the stage after it is full and stalled, so bubbles close up.
// Configuration registers are written directly and must only change while no
// transfer is in flight.
module battery_cell_count_estimator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bcce_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcce_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bcce_pkg::MV_BITS-1:0]         pack_millivolts_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 valid_res_o,
  output logic [bcce_pkg::CNT_W-1:0]           optimistic_cells_o,
  output logic [bcce_pkg::CNT_W-1:0]           pessimistic_cells_o,
  output logic [bcce_pkg::CELL_MV_W-1:0]       optimistic_cell_mv_o,
  output logic [bcce_pkg::CELL_MV_W-1:0]       pessimistic_cell_mv_o
);

  localparam int NS = bcce_pkg::NUM_STAGES;
  localparam int ND = bcce_pkg::DIV_STAGES;

  // Configuration registers.
  bcce_pkg::chem_mode_e           mode_q;
  logic [bcce_pkg::LIM_W-1:0]     lipo_max_q, lihv_max_q, life_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= bcce_pkg::CHEM_NONE;
      lipo_max_q <= bcce_pkg::LIM_W'(6);
      lihv_max_q <= bcce_pkg::LIM_W'(6);
      life_max_q <= bcce_pkg::LIM_W'(6);
    end else if (cfg_we_i) begin
      case (bcce_pkg::cfg_reg_e'(cfg_idx_i))
        bcce_pkg::REG_CHEM_MODE: begin
          mode_q <= bcce_pkg::chem_mode_e'(cfg_wdata_i[bcce_pkg::MODE_W-1:0]);
        end
        bcce_pkg::REG_LIPO_MAX: begin
          lipo_max_q <= cfg_wdata_i[bcce_pkg::LIM_W-1:0];
        end
        bcce_pkg::REG_LIHV_MAX: begin
          lihv_max_q <= cfg_wdata_i[bcce_pkg::LIM_W-1:0];
        end
        bcce_pkg::REG_LIFE_MAX: begin
          life_max_q <= cfg_wdata_i[bcce_pkg::LIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Stage occupancy and per-stage advance. A stage loads when it is empty or
  // when the stage after it loads.
  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // Stage 0: register the sample with its mode, limit and rounding offset.
  logic [bcce_pkg::LIM_W-1:0]   lim_d;
  logic                         bad_d;
  logic [bcce_pkg::CX_W-1:0]    xmax_d;

  always_comb begin
    case (mode_q)
      bcce_pkg::CHEM_LIPO, bcce_pkg::CHEM_LIPO_SAFE: lim_d = lipo_max_q;
      bcce_pkg::CHEM_LIHV, bcce_pkg::CHEM_LIHV_SAFE: lim_d = lihv_max_q;
      default:                                       lim_d = life_max_q;
    endcase
    bad_d  = (pack_millivolts_i == '0) || (mode_q == bcce_pkg::CHEM_NONE) ||
             (mode_q == bcce_pkg::CHEM_INVALID);
    // Adding max - 1 turns the floor divide into a ceiling divide.
    xmax_d = bcce_pkg::CX_W'(pack_millivolts_i) +
             bcce_pkg::CX_W'(bcce_pkg::CELL_MAX_MV[mode_q]) - bcce_pkg::CX_W'(1);
  end

  logic [bcce_pkg::MV_BITS-1:0] mv0_q, mv1_q, mv2_q, mv3_q;
  logic [bcce_pkg::CX_W-1:0]    xmax0_q, xmax1_q, xmax2_q;
  bcce_pkg::chem_mode_e         mode0_q, mode1_q, mode2_q;
  logic [bcce_pkg::LIM_W-1:0]   lim0_q, lim1_q, lim2_q;
  logic                         bad0_q, bad1_q, bad2_q, bad3_q;

  logic [bcce_pkg::CP_W-1:0]    pmin1_q, pmax1_q;
  logic [bcce_pkg::CQ_W-1:0]    qmin_d, qmax_d, qmin2_q, qmax2_q;
  logic [bcce_pkg::CM_W-1:0]    mmin2_q, mmax2_q;

  assign qmin_d = pmin1_q[bcce_pkg::CK +: bcce_pkg::CQ_W];
  assign qmax_d = pmax1_q[bcce_pkg::CK +: bcce_pkg::CQ_W];

  // Stage 3: correct both quotients and apply the fit and clamp rules.
  logic [bcce_pkg::CX_W-1:0]    rmin_d, rmax_d;
  logic [bcce_pkg::CF_W-1:0]    pes_raw_d, opt_raw_d, pes_f_d, opt_f_d, lim_f_d;
  logic [bcce_pkg::CNT_W-1:0]   opt_d, pes_d;

  always_comb begin
    rmin_d    = bcce_pkg::CX_W'(mv2_q) - bcce_pkg::CX_W'(mmin2_q);
    rmax_d    = xmax2_q - bcce_pkg::CX_W'(mmax2_q);
    pes_raw_d = bcce_pkg::CF_W'(qmin2_q) + bcce_pkg::CF_W'(
                rmin_d >= bcce_pkg::CX_W'(bcce_pkg::CELL_MIN_MV[mode2_q]));
    opt_raw_d = bcce_pkg::CF_W'(qmax2_q) + bcce_pkg::CF_W'(
                rmax_d >= bcce_pkg::CX_W'(bcce_pkg::CELL_MAX_MV[mode2_q]));
    lim_f_d   = bcce_pkg::CF_W'(lim2_q);
    pes_f_d   = pes_raw_d;
    opt_f_d   = opt_raw_d;
    // No count keeps every cell inside its range, or the optimistic count is above
    // the limit: report one above the unclamped pessimistic count for both.
    if ((opt_raw_d > lim_f_d) || (opt_raw_d > pes_raw_d)) begin
      pes_f_d = pes_raw_d + bcce_pkg::CF_W'(1);
      opt_f_d = pes_raw_d + bcce_pkg::CF_W'(1);
    end else if (pes_raw_d > lim_f_d) begin
      pes_f_d = lim_f_d;
    end
    if (32'(opt_f_d) > 32'(bcce_pkg::CNT_MAX)) begin
      opt_d = bcce_pkg::CNT_W'(bcce_pkg::CNT_MAX);
    end else begin
      opt_d = bcce_pkg::CNT_W'(opt_f_d);
    end
    if (32'(pes_f_d) > 32'(bcce_pkg::CNT_MAX)) begin
      pes_d = bcce_pkg::CNT_W'(bcce_pkg::CNT_MAX);
    end else begin
      pes_d = bcce_pkg::CNT_W'(pes_f_d);
    end
  end

  logic [bcce_pkg::CNT_W-1:0]   opt3_q, pes3_q;
  logic [bcce_pkg::CNT_W-1:0]   opt_pipe_q [ND];
  logic [bcce_pkg::CNT_W-1:0]   pes_pipe_q [ND];
  logic                         bad_pipe_q [ND];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mv0_q   <= pack_millivolts_i;
      xmax0_q <= xmax_d;
      mode0_q <= mode_q;
      lim0_q  <= lim_d;
      bad0_q  <= bad_d;
    end
    if (en[1]) begin
      pmin1_q <= bcce_pkg::CP_W'(mv0_q) *
                 bcce_pkg::CP_W'(bcce_pkg::RECIP_MIN[mode0_q]);
      pmax1_q <= bcce_pkg::CP_W'(xmax0_q) *
                 bcce_pkg::CP_W'(bcce_pkg::RECIP_MAX[mode0_q]);
      mv1_q   <= mv0_q;
      xmax1_q <= xmax0_q;
      mode1_q <= mode0_q;
      lim1_q  <= lim0_q;
      bad1_q  <= bad0_q;
    end
    if (en[2]) begin
      mmin2_q <= bcce_pkg::CM_W'(qmin_d) *
                 bcce_pkg::CM_W'(bcce_pkg::CELL_MIN_MV[mode1_q]);
      mmax2_q <= bcce_pkg::CM_W'(qmax_d) *
                 bcce_pkg::CM_W'(bcce_pkg::CELL_MAX_MV[mode1_q]);
      qmin2_q <= qmin_d;
      qmax2_q <= qmax_d;
      mv2_q   <= mv1_q;
      xmax2_q <= xmax1_q;
      mode2_q <= mode1_q;
      lim2_q  <= lim1_q;
      bad2_q  <= bad1_q;
    end
    if (en[3]) begin
      opt3_q <= opt_d;
      pes3_q <= pes_d;
      mv3_q  <= mv2_q;
      bad3_q <= bad2_q;
    end
    if (en[4]) begin
      opt_pipe_q[0] <= opt3_q;
      pes_pipe_q[0] <= pes3_q;
      bad_pipe_q[0] <= bad3_q;
    end
    for (int k = 1; k < ND; k++) begin
      if (en[4+k]) begin
        opt_pipe_q[k] <= opt_pipe_q[k-1];
        pes_pipe_q[k] <= pes_pipe_q[k-1];
        bad_pipe_q[k] <= bad_pipe_q[k-1];
      end
    end
  end

  // Stages 4 to 6: per-cell voltage for each count.
  logic [bcce_pkg::CELL_MV_W-1:0] opt_mv, pes_mv;

  bcce_cell_div u_opt_div (
    .clk_i     (clk_i),
    .en_i      (en[NS-1:NS-ND]),
    .mv_i      (mv3_q),
    .cnt_i     (opt3_q),
    .cell_mv_o (opt_mv)
  );

  bcce_cell_div u_pes_div (
    .clk_i     (clk_i),
    .en_i      (en[NS-1:NS-ND]),
    .mv_i      (mv3_q),
    .cnt_i     (pes3_q),
    .cell_mv_o (pes_mv)
  );

  // Zero voltage or an unusable mode reports an empty estimate.
  assign valid_res_o           = !bad_pipe_q[ND-1];
  assign optimistic_cells_o    = bad_pipe_q[ND-1] ? '0 : opt_pipe_q[ND-1];
  assign pessimistic_cells_o   = bad_pipe_q[ND-1] ? '0 : pes_pipe_q[ND-1];
  assign optimistic_cell_mv_o  = bad_pipe_q[ND-1] ? '0 : opt_mv;
  assign pessimistic_cell_mv_o = bad_pipe_q[ND-1] ? '0 : pes_mv;

endmodule
